// File: hdl/qte_pkg.sv
// Shared widths, payload type and arctangent table for the quaternion to Euler angle pipeline.
package qte_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int TAB_LEN          = 24;
    localparam int QW               = 16;  // quaternion component width
    localparam int PRW              = 32;  // component product width
    localparam int PSW              = 34;  // atan2 argument width after sums
    localparam int SW               = 30;  // clamped sine term, +-2^28
    localparam int VW               = 57;  // 1 - s*s in Q.56
    localparam int RW               = 29;  // square root result, Q.28
    localparam int SQ_ITER          = 29;  // one result bit per iteration
    localparam int CW               = 38;  // CORDIC x/y width with growth
    localparam int ZW               = 34;  // angle accumulator, pi = 2^31

    localparam logic signed [PSW-1:0] Q28_ONE     = PSW'(64'sd268435456);
    localparam logic signed [ZW-1:0]  ANG_HALF_PI = ZW'(64'sd1073741824);
    localparam logic signed [ZW-1:0]  ANG_PI      = ZW'(64'sd2147483648);

    typedef struct packed {
        logic signed [PSW-1:0] roll_y;
        logic signed [PSW-1:0] roll_x;
        logic signed [PSW-1:0] yaw_y;
        logic signed [PSW-1:0] yaw_x;
        logic signed [SW-1:0]  sin_p;
        logic                  clamped;
    } frt_t;

    // atan(2^-i), pi = 2^31
    function automatic logic signed [ZW-1:0] atan_tab(input int idx);
        logic signed [ZW-1:0] r;
        case (idx)
            0:  r = ZW'(64'h20000000);
            1:  r = ZW'(64'h12E4051E);
            2:  r = ZW'(64'h09FB385B);
            3:  r = ZW'(64'h051111D4);
            4:  r = ZW'(64'h028B0D43);
            5:  r = ZW'(64'h0145D7E1);
            6:  r = ZW'(64'h00A2F61E);
            7:  r = ZW'(64'h00517C55);
            8:  r = ZW'(64'h0028BE53);
            9:  r = ZW'(64'h00145F2F);
            10: r = ZW'(64'h000A2F98);
            11: r = ZW'(64'h000517CC);
            12: r = ZW'(64'h00028BE6);
            13: r = ZW'(64'h000145F3);
            14: r = ZW'(64'h0000A2FA);
            15: r = ZW'(64'h0000517D);
            16: r = ZW'(64'h000028BE);
            17: r = ZW'(64'h0000145F);
            18: r = ZW'(64'h00000A30);
            19: r = ZW'(64'h00000518);
            20: r = ZW'(64'h0000028C);
            21: r = ZW'(64'h00000146);
            22: r = ZW'(64'h000000A3);
            23: r = ZW'(64'h00000051);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// File: hdl/qte_front.sv
// Front end: component products, atan2 arguments, sine clamp and 1 - s*s.
module qte_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            ce,
    input  logic                            in_valid,
    input  logic signed [qte_pkg::QW-1:0]   quat_x,
    input  logic signed [qte_pkg::QW-1:0]   quat_y,
    input  logic signed [qte_pkg::QW-1:0]   quat_z,
    input  logic signed [qte_pkg::QW-1:0]   quat_w,
    output logic                            out_valid,
    output qte_pkg::frt_t                   out_pay,
    output logic [qte_pkg::VW-1:0]          out_v
);

    localparam int PSW = qte_pkg::PSW;
    localparam int PRW = qte_pkg::PRW;
    localparam int SW  = qte_pkg::SW;
    localparam int VW  = qte_pkg::VW;

    logic a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg;

    logic signed [qte_pkg::QW-1:0] x_reg, y_reg, z_reg, w_reg;
    logic signed [PRW-1:0] wx_reg, yz_reg, xx_reg, yy_reg, zz_reg;
    logic signed [PRW-1:0] wz_reg, xy_reg, wy_reg, zx_reg;
    qte_pkg::frt_t c_pay_reg, c_pay_next, d_pay_reg;
    logic [VW-1:0] v_reg;

    logic signed [PSW-1:0] s_full;
    logic signed [2*SW-1:0] ss;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end else if (ce) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_comb begin
        c_pay_next.roll_y = (PSW'(wx_reg) + PSW'(yz_reg)) <<< 1;
        c_pay_next.roll_x = qte_pkg::Q28_ONE - ((PSW'(xx_reg) + PSW'(yy_reg)) <<< 1);
        c_pay_next.yaw_y  = (PSW'(wz_reg) + PSW'(xy_reg)) <<< 1;
        c_pay_next.yaw_x  = qte_pkg::Q28_ONE - ((PSW'(yy_reg) + PSW'(zz_reg)) <<< 1);
        s_full = (PSW'(wy_reg) - PSW'(zx_reg)) <<< 1;
        if (s_full > qte_pkg::Q28_ONE) begin
            c_pay_next.sin_p   = SW'(qte_pkg::Q28_ONE);
            c_pay_next.clamped = 1'b1;
        end else if (s_full < -qte_pkg::Q28_ONE) begin
            c_pay_next.sin_p   = -SW'(qte_pkg::Q28_ONE);
            c_pay_next.clamped = 1'b1;
        end else begin
            c_pay_next.sin_p   = SW'(s_full);
            c_pay_next.clamped = 1'b0;
        end
    end

    assign ss = c_pay_reg.sin_p * c_pay_reg.sin_p;

    always_ff @(posedge aclk) begin
        if (ce) begin
            x_reg <= quat_x;
            y_reg <= quat_y;
            z_reg <= quat_z;
            w_reg <= quat_w;
            wx_reg <= w_reg * x_reg;
            yz_reg <= y_reg * z_reg;
            xx_reg <= x_reg * x_reg;
            yy_reg <= y_reg * y_reg;
            zz_reg <= z_reg * z_reg;
            wz_reg <= w_reg * z_reg;
            xy_reg <= x_reg * y_reg;
            wy_reg <= w_reg * y_reg;
            zx_reg <= z_reg * x_reg;
            c_pay_reg <= c_pay_next;
            d_pay_reg <= c_pay_reg;
            // s*s never exceeds 2^56
            v_reg <= (VW'(1) << (VW - 1)) - VW'(ss);
        end
    end

    assign out_valid = d_valid_reg;
    assign out_pay   = d_pay_reg;
    assign out_v     = v_reg;

endmodule

// File: hdl/qte_isqrt.sv
// Pipelined floor square root, one result bit per stage, with a payload carried alongside.
module qte_isqrt #(
    parameter int PW = 1
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      ce,
    input  logic                      in_valid,
    input  logic [qte_pkg::VW-1:0]    in_v,
    input  logic [PW-1:0]             in_pay,
    output logic                      out_valid,
    output logic [qte_pkg::RW-1:0]    out_root,
    output logic [PW-1:0]             out_pay
);

    localparam int VW = qte_pkg::VW;
    localparam int N  = qte_pkg::SQ_ITER;

    logic [VW-1:0] rem_reg [N];
    logic [VW-1:0] res_reg [N];
    logic [PW-1:0] pay_reg [N];
    logic          vld_reg [N];

    for (genvar k = 0; k < N; k++) begin : g_it
        localparam logic [VW:0] BIT = (VW + 1)'(1) << (VW - 1 - 2 * k);
        logic [VW-1:0] rem_in, res_in, rem_next, res_next;
        logic [VW:0]   trial;
        logic [PW-1:0] pay_in;
        logic          vld_in;

        if (k == 0) begin : g_first
            assign rem_in = in_v;
            assign res_in = '0;
            assign pay_in = in_pay;
            assign vld_in = in_valid;
        end else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign res_in = res_reg[k-1];
            assign pay_in = pay_reg[k-1];
            assign vld_in = vld_reg[k-1];
        end

        assign trial = {1'b0, res_in} + BIT;

        always_comb begin
            if ({1'b0, rem_in} >= trial) begin
                rem_next = rem_in - trial[VW-1:0];
                res_next = (res_in >> 1) + BIT[VW-1:0];
            end else begin
                rem_next = rem_in;
                res_next = res_in >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (ce) begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[k] <= rem_next;
                res_reg[k] <= res_next;
                pay_reg[k] <= pay_in;
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign out_root  = res_reg[N-1][qte_pkg::RW-1:0];
    assign out_pay   = pay_reg[N-1];

endmodule

// File: hdl/qte_cordic.sv
// Pipelined vectoring CORDIC atan2, one iteration per stage, 16-bit binary angle out.
module qte_cordic #(
    parameter int STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            ce,
    input  logic                            in_valid,
    input  logic signed [qte_pkg::CW-1:0]   in_y,
    input  logic signed [qte_pkg::CW-1:0]   in_x,
    output logic                            out_valid,
    output logic [15:0]                     out_angle
);

    localparam int CW = qte_pkg::CW;
    localparam int ZW = qte_pkg::ZW;

    // stage 0 is the quadrant fold, stages 1..STEPS the iterations
    logic signed [CW-1:0] x_reg [STEPS+1];
    logic signed [CW-1:0] y_reg [STEPS+1];
    logic signed [ZW-1:0] z_reg [STEPS+1];
    logic                 sp_reg [STEPS+1];
    logic signed [ZW-1:0] spz_reg [STEPS+1];
    logic                 vld_reg [STEPS+1];
    logic                 out_valid_reg;
    logic [15:0]          out_angle_reg;

    logic signed [CW-1:0] x0_next, y0_next;
    logic signed [ZW-1:0] z0_next, spz0_next, ang, rnd;
    logic                 sp0_next;

    always_comb begin
        x0_next   = in_x;
        y0_next   = in_y;
        z0_next   = '0;
        sp0_next  = 1'b0;
        spz0_next = '0;
        if (in_x == '0) begin
            sp0_next = 1'b1;
            if (in_y > 0) begin
                spz0_next = qte_pkg::ANG_HALF_PI;
            end else if (in_y < 0) begin
                spz0_next = -qte_pkg::ANG_HALF_PI;
            end
        end else if (in_y == '0) begin
            sp0_next  = 1'b1;
            spz0_next = (in_x > 0) ? '0 : qte_pkg::ANG_PI;
        end else if (in_x < 0) begin
            if (in_y >= 0) begin
                x0_next = in_y;
                y0_next = -in_x;
                z0_next = qte_pkg::ANG_HALF_PI;
            end else begin
                x0_next = -in_y;
                y0_next = in_x;
                z0_next = -qte_pkg::ANG_HALF_PI;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (ce) begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            x_reg[0]   <= x0_next;
            y_reg[0]   <= y0_next;
            z_reg[0]   <= z0_next;
            sp_reg[0]  <= sp0_next;
            spz_reg[0] <= spz0_next;
        end
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        localparam logic signed [ZW-1:0] ATAN = qte_pkg::atan_tab(i);
        logic signed [CW-1:0] xs, ys, x_next, y_next;
        logic signed [ZW-1:0] z_next;

        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;

        always_comb begin
            if (!y_reg[i][CW-1]) begin
                x_next = x_reg[i] + ys;
                y_next = y_reg[i] - xs;
                z_next = z_reg[i] + ATAN;
            end else begin
                x_next = x_reg[i] - ys;
                y_next = y_reg[i] + xs;
                z_next = z_reg[i] - ATAN;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i+1] <= 1'b0;
            end else if (ce) begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                x_reg[i+1]   <= x_next;
                y_reg[i+1]   <= y_next;
                z_reg[i+1]   <= z_next;
                sp_reg[i+1]  <= sp_reg[i];
                spz_reg[i+1] <= spz_reg[i];
            end
        end
    end

    // round to nearest 2^16 unit, wrap to 16 bits
    assign ang = sp_reg[STEPS] ? spz_reg[STEPS] : z_reg[STEPS];
    assign rnd = ang + ZW'(32768);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ce) begin
            out_valid_reg <= vld_reg[STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            out_angle_reg <= rnd[31:16];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_angle = out_angle_reg;

endmodule

// File: hdl/quaternion_to_euler_angles.sv
// Pipeline: 4 front stages, 29 square-root stages, CORDIC_STEPS + 2 CORDIC stages.
// The three angles run in parallel CORDIC pipelines.
// Throughput: one quaternion per cycle; the whole pipeline advances when the output
// register is empty or its transfer completes.
// Reset: synchronous active-low aresetn clears all valid bits; the block keeps no state.
module quaternion_to_euler_angles #(
    parameter int CORDIC_STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // quat_x, quat_y, quat_z, quat_w
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // roll_angle, pitch_angle, yaw_angle
    output logic [0:0]  m_tuser    // pitch_clamped
);

    localparam int CW = qte_pkg::CW;
    localparam int PW = $bits(qte_pkg::frt_t);
    localparam int CL = CORDIC_STEPS + 2;

    logic ce;
    logic fr_valid, sq_valid;
    qte_pkg::frt_t fr_pay, sq_pay;
    logic [qte_pkg::VW-1:0] fr_v;
    logic [qte_pkg::RW-1:0] sq_root;
    logic [PW-1:0] sq_pay_bits;
    logic roll_valid, pitch_valid, yaw_valid;
    logic [15:0] roll_angle, pitch_angle, yaw_angle;
    logic clamp_reg [CL];

    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;

    qte_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (s_tvalid),
        .quat_x    (s_tdata[15:0]),
        .quat_y    (s_tdata[31:16]),
        .quat_z    (s_tdata[47:32]),
        .quat_w    (s_tdata[63:48]),
        .out_valid (fr_valid),
        .out_pay   (fr_pay),
        .out_v     (fr_v)
    );

    qte_isqrt #(.PW(PW)) u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (fr_valid),
        .in_v      (fr_v),
        .in_pay    (fr_pay),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_pay   (sq_pay_bits)
    );

    assign sq_pay = qte_pkg::frt_t'(sq_pay_bits);

    qte_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (sq_valid),
        .in_y      (CW'(sq_pay.roll_y)),
        .in_x      (CW'(sq_pay.roll_x)),
        .out_valid (roll_valid),
        .out_angle (roll_angle)
    );

    qte_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (sq_valid),
        .in_y      (CW'(sq_pay.sin_p)),
        .in_x      ($signed(CW'(sq_root))),
        .out_valid (pitch_valid),
        .out_angle (pitch_angle)
    );

    qte_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (sq_valid),
        .in_y      (CW'(sq_pay.yaw_y)),
        .in_x      (CW'(sq_pay.yaw_x)),
        .out_valid (yaw_valid),
        .out_angle (yaw_angle)
    );

    // clamp flag follows the CORDIC latency
    always_ff @(posedge aclk) begin
        if (ce) begin
            clamp_reg[0] <= sq_pay.clamped;
            for (int i = 1; i < CL; i++) begin
                clamp_reg[i] <= clamp_reg[i-1];
            end
        end
    end

    // all three CORDIC pipelines move in lockstep
    assign m_tvalid = roll_valid && pitch_valid && yaw_valid;
    assign m_tdata  = {yaw_angle, pitch_angle, roll_angle};
    assign m_tuser  = clamp_reg[CL-1];

endmodule

// File: tb/tb_top.sv
// Testbench for the quaternion to Euler angle pipeline: directed and random quaternions.
`timescale 1ns / 1ps

module tb_top;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic               clamped;
    } euler_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;   // quat_x, quat_y, quat_z, quat_w
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;        // roll_angle, pitch_angle, yaw_angle
    logic [0:0]  m_tuser;        // pitch_clamped

    euler_t expected_angles[$];
    int     err_count = 0;
    int     sink_idle = 0;
    bit     sink_stalls = 1'b0;
    bit     src_gaps = 1'b0;
    bit     hold_off = 1'b0;

    always #1 aclk = ~aclk;

    quaternion_to_euler_angles u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    localparam longint HALF_PI_U = 64'sd1073741824;
    localparam longint PI_U      = 64'sd2147483648;
    localparam longint ONE_Q28   = 64'sd268435456;

    function automatic longint atan_step(int i);
        case (i)
            0:  return 64'h20000000;  1:  return 64'h12E4051E;
            2:  return 64'h09FB385B;  3:  return 64'h051111D4;
            4:  return 64'h028B0D43;  5:  return 64'h0145D7E1;
            6:  return 64'h00A2F61E;  7:  return 64'h00517C55;
            8:  return 64'h0028BE53;  9:  return 64'h00145F2F;
            10: return 64'h000A2F98;  11: return 64'h000517CC;
            12: return 64'h00028BE6;  13: return 64'h000145F3;
            14: return 64'h0000A2FA;  15: return 64'h0000517D;
            default: return 0;
        endcase
    endfunction

    // vectoring CORDIC, pi = 2^31; >>> on longint floors
    function automatic longint vector_angle(longint y, longint x);
        longint z, t, xs, ys;
        z = 0;
        if (x == 0) return (y > 0) ? HALF_PI_U : (y < 0) ? -HALF_PI_U : 0;
        if (y == 0) return (x > 0) ? 0 : PI_U;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; z = HALF_PI_U;
            end else begin
                x = -y; y = t; z = -HALF_PI_U;
            end
        end
        for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x += ys; y -= xs; z += atan_step(i);
            end else begin
                x -= ys; y += xs; z -= atan_step(i);
            end
        end
        return z;
    endfunction

    function automatic logic [15:0] to_binang(longint a);
        longint r;
        r = (a + 32768) >>> 16;
        return r[15:0];
    endfunction

    function automatic longint floor_sqrt(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic euler_t quat_to_euler(logic [63:0] q);
        longint qx, qy, qz, qw, s, c;
        euler_t e;
        qx = longint'($signed(q[15:0]));
        qy = longint'($signed(q[31:16]));
        qz = longint'($signed(q[47:32]));
        qw = longint'($signed(q[63:48]));
        s = 2 * (qw * qy - qz * qx);
        e.clamped = 1'b0;
        if (s > ONE_Q28) begin
            s = ONE_Q28; e.clamped = 1'b1;
        end else if (s < -ONE_Q28) begin
            s = -ONE_Q28; e.clamped = 1'b1;
        end
        c = floor_sqrt((64'd1 << 56) - longint'(s * s));
        e.roll  = to_binang(vector_angle(2 * (qw * qx + qy * qz),
                                         ONE_Q28 - 2 * (qx * qx + qy * qy)));
        e.pitch = to_binang(vector_angle(s, c));
        e.yaw   = to_binang(vector_angle(2 * (qw * qz + qx * qy),
                                         ONE_Q28 - 2 * (qy * qy + qz * qz)));
        return e;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d expected %0d", what, got, want);
        err_count++;
    endtask

    // one quaternion transfer, with optional random gap before it;
    // tvalid stays high into the next call when no gap follows
    task automatic send_quat(logic signed [15:0] x, y, z, w);
        if (src_gaps && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge aclk);
        end
        s_tdata  <= {w, z, y, x};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        expected_angles.push_back(quat_to_euler({w, z, y, x}));
        @(negedge aclk);
    endtask

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(0, 4))
            0: return 16'($urandom_range(0, 32768)) - 16'sd16384;
            1: return 16'($urandom);
            2: return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
            3: return 16'($urandom_range(0, 64)) - 16'sd32;
            default: return 16'($urandom_range(0, 2000)) - 16'sd1000;
        endcase
    endfunction

    // sink side: random stall bursts and the long hold-off
    always @(negedge aclk) begin
        if (hold_off) begin
            m_tready <= 1'b0;
        end else if (sink_idle > 0) begin
            m_tready <= 1'b0;
            sink_idle--;
        end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
            m_tready <= 1'b0;
            sink_idle = $urandom_range(0, 16);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        euler_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_angles.size() == 0) begin
                report_mismatch("unexpected transfer", 0, 0);
            end else begin
                want = expected_angles.pop_front();
                if (m_tdata[15:0] !== want.roll)
                    report_mismatch("roll", $signed(m_tdata[15:0]), want.roll);
                if (m_tdata[31:16] !== want.pitch)
                    report_mismatch("pitch", $signed(m_tdata[31:16]), want.pitch);
                if (m_tdata[47:32] !== want.yaw)
                    report_mismatch("yaw", $signed(m_tdata[47:32]), want.yaw);
                if (m_tuser[0] !== want.clamped)
                    report_mismatch("pitch_clamped", m_tuser[0], want.clamped);
            end
        end
    end

    task automatic test_directed();
        send_quat(0, 0, 0, 16384);            // identity
        send_quat(0, 0, 0, 0);                // all zero quaternion
        send_quat(8192, 8192, 0, 0);          // roll: both atan2 args zero
        send_quat(16384, 0, 0, 0);            // roll = pi, wraps
        send_quat(0, 0, 16384, 0);            // yaw = pi
        send_quat(0, 16384, 0, 16384);        // pitch term 2: clamped
        send_quat(0, -16384, 0, 16384);       // clamped negative
        send_quat(0, 11585, 0, 11585);        // pitch just below +half pi, not clamped
        send_quat(11585, 0, 0, 11585);        // roll half pi
        send_quat(-32768, -32768, -32768, -32768);
        send_quat(32767, 32767, 32767, 32767);
        send_quat(32767, -32768, 32767, -32768);
        send_quat(-16384, 16384, -16384, 16384);
        send_quat(16384, 16384, 16384, 16384);
        send_quat(1, 0, 0, -16384);           // near zero roll
        send_quat(-1, 0, 0, -16384);
        send_quat(0, 0, 1, -16384);
        send_quat(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
        send_quat(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
    endtask

    task automatic test_random(int n);
        repeat (n) send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
    endtask

    // sink stops for a long stretch while quaternions keep coming
    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (200) @(posedge aclk);
                hold_off = 1'b0;
            end
            test_random(150);
        join
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        src_gaps = 1'b1;
        sink_stalls = 1'b1;
        test_random(700);
        test_backpressure();
        test_random(400);
        src_gaps = 1'b0;
        sink_stalls = 1'b0;
        test_random(400);
        s_tvalid <= 1'b0;
        while (expected_angles.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #400000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
